@@ src/hba_pkg.sv @@
// hba_pkg: shared types, constants and codes of the hierarchical bitmap allocator
// no dependencies; imported by the allocator top level and its checker

package hba_pkg;

  localparam int CAPACITY  = 4096;
  localparam int LEVELS    = 4;
  localparam int WORD_W    = 8;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int LVL_W     = $clog2(LEVELS);

  localparam int ENTRY_W   = 12;
  localparam int COUNT_W   = 13;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;

  // words per level and their place in the shared word store
  localparam int LEN0      = (CAPACITY + WORD_W - 1) / WORD_W;
  localparam int LEN1      = (LEN0 + WORD_W - 1) / WORD_W;
  localparam int LEN2      = (LEN1 + WORD_W - 1) / WORD_W;
  localparam int LEN3      = (LEN2 + WORD_W - 1) / WORD_W;
  localparam int BASE1     = LEN0;
  localparam int BASE2     = BASE1 + LEN1;
  localparam int BASE3     = BASE2 + LEN2;
  localparam int RAM_DEPTH = BASE3 + LEN3;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);

  localparam logic [WORD_W-1:0] WORD_FULL = {WORD_W{1'b1}};
  localparam logic [LVL_W-1:0]  LEVEL_TOP = LVL_W'(LEVELS - 1);

  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MARK    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DOWN,
    S_UP_WR,
    S_DONE
  } state_t;

endpackage

@@ src/hba_ram.sv @@
// hba_ram: generic single-write, single-read memory with registered read data
// depends on nothing; used for the allocator's word store

module hba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/hierarchical_bitmap_allocator_top.sv @@
// hierarchical_bitmap_allocator_top: four-level bitmap free list in one word store
// depends on hba_pkg and hba_ram
// mark/release rewrite the leaf word, then each level above while a word fills or was full;
// out of range skips the store; allocate descends from the top level, then updates upward
// one request in flight; the next is taken the cycle after its result is registered
// reset or a count write starts a clearing pass over all 585 store words, no requests taken

module hierarchical_bitmap_allocator_top import hba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [KIND_W-1:0]   kind,
  input  logic [ENTRY_W-1:0]  index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ENTRY_W-1:0]  entry,
  output logic [STATUS_W-1:0] status,
  input  logic                cfg_wr_en,
  input  logic [COUNT_W-1:0]  count_in_use
);

  state_t              state, state_next;
  logic [LVL_W-1:0]    lvl, lvl_next;
  logic [ENTRY_W-1:0]  pos, pos_next;
  logic                op_set, op_set_next;
  logic [ENTRY_W-1:0]  res_entry, res_entry_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [ADDR_W-1:0]   clr_addr, clr_addr_next;
  logic [COUNT_W-1:0]  count_limit, count_limit_next;
  logic                out_valid_next;
  logic [ENTRY_W-1:0]  entry_next;
  logic [STATUS_W-1:0] status_next;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata;

  logic [BIT_W-1:0]    free_bit;
  logic [ENTRY_W-1:0]  down_pos;
  logic [WORD_W-1:0]   bit_mask, upd_word;
  logic                carry;

  function automatic logic [ADDR_W-1:0] level_base(input logic [LVL_W-1:0] l);
    logic [ADDR_W-1:0] b;
    case (l)
      2'd0:    b = '0;
      2'd1:    b = ADDR_W'(BASE1);
      2'd2:    b = ADDR_W'(BASE2);
      2'd3:    b = ADDR_W'(BASE3);
      default: b = '0;
    endcase
    return b;
  endfunction

  // address of the level-l word that covers entry e
  function automatic logic [ADDR_W-1:0] word_addr(input logic [LVL_W-1:0] l,
                                                  input logic [ENTRY_W-1:0] e);
    logic [ENTRY_W-1:0] widx;
    widx = e >> (BIT_W * (int'(l) + 1));
    return level_base(l) + ADDR_W'(widx);
  endfunction

  // reset contents of one store word: a bit is set when its subtree starts at or past count
  function automatic logic [WORD_W-1:0] pad_word(input logic [ADDR_W-1:0] a,
                                                 input logic [COUNT_W-1:0] cnt);
    logic [LVL_W-1:0]   l;
    logic [ADDR_W-1:0]  widx;
    logic [COUNT_W-1:0] start;
    logic [WORD_W-1:0]  w;
    if (a < ADDR_W'(BASE1)) begin
      l = 2'd0;
      widx = a;
    end else if (a < ADDR_W'(BASE2)) begin
      l = 2'd1;
      widx = a - ADDR_W'(BASE1);
    end else if (a < ADDR_W'(BASE3)) begin
      l = 2'd2;
      widx = a - ADDR_W'(BASE2);
    end else begin
      l = 2'd3;
      widx = a - ADDR_W'(BASE3);
    end
    for (int b = 0; b < WORD_W; b++) begin
      start = COUNT_W'({widx, BIT_W'(b)}) << (BIT_W * int'(l));
      w[b] = (start >= cnt);
    end
    return w;
  endfunction

  hba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      count_limit <= COUNT_W'(CAPACITY);
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      clr_addr    <= clr_addr_next;
      count_limit <= count_limit_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    lvl        <= lvl_next;
    pos        <= pos_next;
    op_set     <= op_set_next;
    res_entry  <= res_entry_next;
    res_status <= res_status_next;
    entry      <= entry_next;
    status     <= status_next;
  end

  // lowest zero bit of the word read during the descent
  always_comb begin
    free_bit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!ram_rdata[b]) begin
        free_bit = BIT_W'(b);
      end
    end
    down_pos = ENTRY_W'({pos, free_bit});
  end

  // read-modify-write of one level on the way up
  always_comb begin
    logic [BIT_W-1:0] bsel;
    bsel     = BIT_W'(pos >> (BIT_W * int'(lvl)));
    bit_mask = WORD_W'(1) << bsel;
    upd_word = op_set ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
    carry    = op_set ? (upd_word == WORD_FULL) : (ram_rdata == WORD_FULL);
  end

  always_comb begin
    state_next       = state;
    lvl_next         = lvl;
    pos_next         = pos;
    op_set_next      = op_set;
    res_entry_next   = res_entry;
    res_status_next  = res_status;
    clr_addr_next    = clr_addr;
    count_limit_next = count_limit;
    out_valid_next   = out_valid && !out_ready;
    entry_next       = entry;
    status_next      = status;
    ram_we           = 1'b0;
    ram_waddr        = '0;
    ram_wdata        = '0;
    ram_raddr        = '0;
    in_ready         = (state == S_IDLE);

    case (state)
      S_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        ram_wdata     = pad_word(clr_addr, count_limit);
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == ADDR_W'(RAM_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          res_entry_next  = index;
          res_status_next = ST_OK;
          case (kind)
            KIND_ALLOC: begin
              ram_raddr  = level_base(LEVEL_TOP);
              lvl_next   = LEVEL_TOP;
              pos_next   = '0;
              state_next = S_DOWN;
            end
            KIND_MARK, KIND_RELEASE: begin
              if ({1'b0, index} >= count_limit) begin
                res_status_next = ST_RANGE;
                state_next      = S_DONE;
              end else begin
                ram_raddr   = word_addr('0, index);
                pos_next    = index;
                lvl_next    = '0;
                op_set_next = (kind == KIND_MARK);
                state_next  = S_UP_WR;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_DOWN: begin
        if (ram_rdata == WORD_FULL) begin
          res_entry_next  = '0;
          res_status_next = ST_NOFREE;
          state_next      = S_DONE;
        end else if (lvl == '0) begin
          if ({1'b0, down_pos} >= count_limit) begin
            res_entry_next  = '0;
            res_status_next = ST_NOFREE;
            state_next      = S_DONE;
          end else begin
            // found leaf; re-read it and mark it used on the way up
            res_entry_next = down_pos;
            pos_next       = down_pos;
            op_set_next    = 1'b1;
            ram_raddr      = word_addr('0, down_pos);
            state_next     = S_UP_WR;
          end
        end else begin
          lvl_next  = lvl - 1'b1;
          pos_next  = down_pos;
          ram_raddr = level_base(lvl - 1'b1) + ADDR_W'(down_pos);
        end
      end
      S_UP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = word_addr(lvl, pos);
        ram_wdata = upd_word;
        if (carry && lvl != LEVEL_TOP) begin
          lvl_next  = lvl + 1'b1;
          ram_raddr = word_addr(lvl + 1'b1, pos);
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          entry_next     = res_entry;
          status_next    = res_status;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase

    // a count write rebuilds every level
    if (cfg_wr_en) begin
      count_limit_next = (count_in_use > COUNT_W'(CAPACITY)) ? COUNT_W'(CAPACITY)
                                                             : count_in_use;
      clr_addr_next    = '0;
      state_next       = S_CLEAR;
    end
  end

endmodule

@@ src/hba_checker.sv @@
// hba_checker: port-level assertions for the hierarchical bitmap allocator
// depends on hba_pkg; bound to hierarchical_bitmap_allocator_top below

module hba_checker import hba_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic [KIND_W-1:0]   kind,
  input logic [ENTRY_W-1:0]  index,
  input logic                out_valid,
  input logic                out_ready,
  input logic [ENTRY_W-1:0]  entry,
  input logic [STATUS_W-1:0] status,
  input logic                cfg_wr_en,
  input logic [COUNT_W-1:0]  count_in_use
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(entry) && $stable(status))
    else $error("result changed while stalled");

  // a failed allocate reports entry zero
  a_nofree_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NOFREE |-> entry == '0)
    else $error("no-free result with nonzero entry");

  // only one request in flight
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted back to back");

  // a count write starts the clearing pass
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> !in_ready)
    else $error("ready during store rebuild");

  // reset empties the output and blocks requests
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("bad state after reset");

endmodule

bind hierarchical_bitmap_allocator_top hba_checker u_hba_checker (.*);
